/* src/decimal_text_to_int32_assert.svh */
// ----------------------------------------------------------------------------
// decimal_text_to_int32 assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TEXT_TO_INT32_ASSERT_SVH
`define DECIMAL_TEXT_TO_INT32_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define DTTI_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante
`define DTTI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/dtti_pkg.sv */
// ----------------------------------------------------------------------------
// dtti_pkg
// Shared types and constants of the decimal text to int32 converter.
// ----------------------------------------------------------------------------
package dtti_pkg;

	// Character codes
	localparam logic [7:0] CHAR_SPACE = 8'd32;
	localparam logic [7:0] CHAR_TAB   = 8'd9;
	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] CHAR_PLUS  = 8'd43;
	localparam logic [7:0] CHAR_MINUS = 8'd45;
	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_NINE  = 8'd57;

	// Result limits
	localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

	// Queue between front and back (power of two)
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		CC_SPACE,
		CC_PLUS,
		CC_MINUS,
		CC_DIGIT,
		CC_OTHER
	} char_class_t;

	typedef enum logic [1:0] {
		PH_SKIP,
		PH_SIGN,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	// One classified character
	typedef struct packed {
		char_class_t cls;
		logic [3:0]  digit;
		logic        last;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

/* src/decimal_text_to_int32.sv */
// ----------------------------------------------------------------------------
// decimal_text_to_int32
// Saturating decimal string to signed 32-bit integer converter.
// ----------------------------------------------------------------------------
// Takes one character per cycle while the queue has room and returns the
// integer on the character marked last. Leading whitespace is skipped, one
// '+' or '-' is accepted, and digits accumulate with clamping to the int32
// range; the first non-digit ends the number, and whitespace inside the
// number or a stray first character gives 0. An empty string is sent as
// one NUL character. Throughput is one character per clock unless the
// queue is full: the multiply-by-ten accumulate in the back end is
// combinational. A last character is written to the two-entry queue and
// loads the output register when popped, which waits for a free output.
// While a result waits to be taken, the next string keeps streaming in up
// to its own last character, which then waits in the queue.
// ----------------------------------------------------------------------------
`include "decimal_text_to_int32_assert.svh"

module decimal_text_to_int32
	import dtti_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         char_code,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] value
);

	queue_stat_t q_stat;
	item_t       push_item;
	item_t       head;
	logic        push;
	logic        pop;

	// Classify incoming characters
	dtti_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_code (char_code),
		.last      (last),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	// Buffer between front and back
	dtti_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	// Parse and accumulate
	dtti_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value)
	);

	// Checks
	`DTTI_ASSERT_SAME(a_queue_stat, 1'b1, !(q_stat.full && q_stat.empty), "queue full and empty")
	`DTTI_ASSERT_SAME(a_pop_nonempty, pop, !q_stat.empty, "pop from empty queue")
	`DTTI_ASSERT_NEXT(a_last_gives_result, pop && head.last, out_valid, "last char gave no result")
	`DTTI_ASSERT_SAME(a_push_has_room, push, !q_stat.full, "push into full queue")

endmodule

/* src/dtti_front.sv */
// ----------------------------------------------------------------------------
// dtti_front
// Accepts characters and classifies them as space, sign, digit or other.
// ----------------------------------------------------------------------------
module dtti_front
	import dtti_pkg::*;
(
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        last,
	input  queue_stat_t q_stat,
	output logic        push,
	output item_t       push_item
);

	// Take a transaction whenever the queue has room
	assign in_ready = !q_stat.full;
	assign push     = in_valid && in_ready;

	// Classify the character
	always_comb begin
		push_item.digit = char_code[3:0];
		push_item.last  = last;
		if (char_code == CHAR_SPACE || (char_code >= CHAR_TAB && char_code <= CHAR_CR)) begin
			push_item.cls = CC_SPACE;
		end else if (char_code == CHAR_PLUS) begin
			push_item.cls = CC_PLUS;
		end else if (char_code == CHAR_MINUS) begin
			push_item.cls = CC_MINUS;
		end else if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE) begin
			push_item.cls = CC_DIGIT;
		end else begin
			push_item.cls = CC_OTHER;
		end
	end

endmodule

/* src/dtti_queue.sv */
// ----------------------------------------------------------------------------
// dtti_queue
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module dtti_queue
	import dtti_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  item_t       push_item,
	input  logic        pop,
	output item_t       head,
	output queue_stat_t q_stat
);

	item_t                  entry_q [QUEUE_DEPTH];
	logic [QUEUE_IDX_W-1:0] wr_ptr_q;
	logic [QUEUE_IDX_W-1:0] rd_ptr_q;
	logic [QUEUE_IDX_W:0]   count_q;

	assign head         = entry_q[rd_ptr_q];
	assign q_stat.full  = (count_q == (QUEUE_IDX_W+1)'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);

	// Store the pushed entry
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* src/dtti_back.sv */
// ----------------------------------------------------------------------------
// dtti_back
// Parses the classified characters, accumulates the signed value with
// saturation and holds the result in an output register.
// ----------------------------------------------------------------------------
module dtti_back
	import dtti_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  item_t              head,
	input  queue_stat_t        q_stat,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] value
);

	localparam logic signed [35:0] WideMax = 36'sh07FFFFFFF;
	localparam logic signed [35:0] WideMin = 36'shF80000000;

	phase_t             phase_q;
	phase_t             phase_next;
	logic               neg_q;
	logic               neg_next;
	logic signed [31:0] acc_q;
	logic signed [31:0] acc_next;
	logic signed [35:0] acc_wide;
	logic signed [35:0] step_sum;
	logic signed [31:0] step_val;
	logic               take_digit;
	logic               zero_out;
	logic               out_valid_q;
	logic signed [31:0] value_q;

	assign out_valid = out_valid_q;
	assign value     = value_q;

	// Pop any non-last character; pop a last one only when the output
	// register is free or being drained
	assign pop = !q_stat.empty && (!head.last || !out_valid_q || out_ready);

	// Multiply by ten, add or subtract the digit, clamp to int32
	always_comb begin
		acc_wide = 36'(acc_q);
		step_sum = (acc_wide <<< 3) + (acc_wide <<< 1);
		if (neg_q) begin
			step_sum = step_sum - $signed({32'd0, head.digit});
		end else begin
			step_sum = step_sum + $signed({32'd0, head.digit});
		end
		if (step_sum > WideMax) begin
			step_val = INT_MAX;
		end else if (step_sum < WideMin) begin
			step_val = INT_MIN;
		end else begin
			step_val = step_sum[31:0];
		end
	end

	// Next phase
	always_comb begin
		phase_next = phase_q;
		case (phase_q)
			PH_SKIP: begin
				if (head.cls == CC_PLUS || head.cls == CC_MINUS) begin
					phase_next = PH_SIGN;
				end else if (head.cls == CC_DIGIT) begin
					phase_next = PH_DIGITS;
				end else if (head.cls != CC_SPACE) begin
					phase_next = PH_DONE;
				end
			end
			PH_SIGN: begin
				phase_next = (head.cls == CC_DIGIT) ? PH_DIGITS : PH_DONE;
			end
			PH_DIGITS: begin
				if (head.cls != CC_DIGIT) begin
					phase_next = PH_DONE;
				end
			end
			PH_DONE:   phase_next = PH_DONE;
			default:   phase_next = PH_SKIP;
		endcase
	end

	// Digit accumulation and zeroing per phase
	always_comb begin
		take_digit = 1'b0;
		zero_out   = 1'b0;
		neg_next   = neg_q;
		case (phase_q)
			PH_SKIP: begin
				if (head.cls == CC_PLUS || head.cls == CC_MINUS) begin
					neg_next = (head.cls == CC_MINUS);
				end else if (head.cls == CC_DIGIT) begin
					take_digit = 1'b1;
				end else if (head.cls != CC_SPACE) begin
					zero_out = 1'b1;
				end
			end
			PH_SIGN: begin
				take_digit = (head.cls == CC_DIGIT);
				zero_out   = (head.cls != CC_DIGIT);
			end
			PH_DIGITS: begin
				take_digit = (head.cls == CC_DIGIT);
				zero_out   = (head.cls == CC_SPACE);
			end
			PH_DONE: begin
				take_digit = 1'b0;
			end
			default: begin
				zero_out = 1'b1;
			end
		endcase
		if (zero_out) begin
			neg_next = 1'b0;
			acc_next = '0;
		end else if (take_digit) begin
			acc_next = step_val;
		end else begin
			acc_next = acc_q;
		end
	end

	// Update parse state; return to reset values after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			neg_q   <= 1'b0;
			acc_q   <= '0;
		end else if (pop) begin
			if (head.last) begin
				phase_q <= PH_SKIP;
				neg_q   <= 1'b0;
				acc_q   <= '0;
			end else begin
				phase_q <= phase_next;
				neg_q   <= neg_next;
				acc_q   <= acc_next;
			end
		end
	end

	// Hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			value_q <= acc_next;
		end
	end

endmodule

/* tb/tb_decimal_text_to_int32.sv */
// ----------------------------------------------------------------------------
// tb_decimal_text_to_int32
// Self-checking bench for the saturating decimal text to int32 converter.
// ----------------------------------------------------------------------------
// Streams strings one character per transaction and predicts the value that
// each string marked last must produce. A scoreboard keeps its own copy of
// the parser state and a queue of pending values, which every output
// transaction is checked against. A short directed list goes first, then
// random strings, mostly well-formed numbers with random content and the
// rest raw noise. Both sides idle at random, with some calm stretches.
// ----------------------------------------------------------------------------
module tb_decimal_text_to_int32
	import dtti_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] CHAR_DOT   = 8'd46;
	localparam int         RANDOM_CHARS = 1700;

	// Parser copy and queue of values still to come out
	class parsed_value_board;
		phase_t             phase;
		bit                 negative;
		logic [31:0]        magnitude;
		logic signed [31:0] pending_values[$];
		int                 errors;
		int                 checked;

		function new();
			restart();
			errors  = 0;
			checked = 0;
		endfunction

		function void restart();
			phase     = PH_SKIP;
			negative  = 1'b0;
			magnitude = 32'd0;
		endfunction

		function bit is_blank(logic [7:0] c);
			return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
		endfunction

		function bit is_numeral(logic [7:0] c);
			return c >= CHAR_ZERO && c <= CHAR_NINE;
		endfunction

		// Multiply by ten and add, clamping the magnitude at 2^31
		function void add_digit(logic [7:0] c);
			logic [35:0] m;
			m = 36'(magnitude) * 36'd10 + (36'(c) - 36'(CHAR_ZERO));
			if (m > 36'h0_8000_0000)
				m = 36'h0_8000_0000;
			magnitude = m[31:0];
		endfunction

		function void clear_number();
			phase     = PH_DONE;
			negative  = 1'b0;
			magnitude = 32'd0;
		endfunction

		// Advance the parser by one accepted character
		function void take_char(logic [7:0] c, bit is_last);
			logic signed [31:0] v;
			case (phase)
				PH_SKIP: begin
					if (is_blank(c)) begin
					end else if (c == CHAR_MINUS || c == CHAR_PLUS) begin
						negative = (c == CHAR_MINUS);
						phase    = PH_SIGN;
					end else if (is_numeral(c)) begin
						add_digit(c);
						phase = PH_DIGITS;
					end else begin
						clear_number();
					end
				end
				PH_SIGN: begin
					if (is_numeral(c)) begin
						add_digit(c);
						phase = PH_DIGITS;
					end else begin
						clear_number();
					end
				end
				PH_DIGITS: begin
					if (is_numeral(c))
						add_digit(c);
					else if (is_blank(c))
						clear_number();
					else
						phase = PH_DONE;
				end
				default: begin
				end
			endcase
			if (is_last) begin
				if (negative)
					v = 32'd0 - magnitude;
				else if (magnitude > 32'h7FFF_FFFF)
					v = INT_MAX;
				else
					v = magnitude;
				pending_values.push_back(v);
				restart();
			end
		endfunction

		// Match one output transaction against the oldest pending value
		function void compare_value(logic signed [31:0] got);
			logic signed [31:0] want;
			if (pending_values.size() == 0) begin
				errors++;
				$display("%0t: unexpected value, expected none, actual %0d", $time, got);
				return;
			end
			want = pending_values.pop_front();
			checked++;
			if (got !== want) begin
				errors++;
				$display("%0t: value mismatch, expected %0d, actual %0d", $time, want, got);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         char_code;
	logic               last;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] value;

	parsed_value_board  board;
	logic [7:0]         text_buf[$];
	bit                 calm = 1'b0;
	int                 strings_sent = 0;
	int                 chars_sent = 0;

	decimal_text_to_int32 i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_code (char_code),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Idle length: mostly none or short, now and then long
	function int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function logic [7:0] pick_blank();
		int r;
		r = $urandom_range(0, 5);
		if (r == 5)
			return CHAR_SPACE;
		return CHAR_TAB + 8'(r);
	endfunction

	function logic [7:0] pick_digit();
		return CHAR_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// Any character that ends a digit run without zeroing it
	function logic [7:0] pick_stopper();
		logic [7:0] c;
		if ($urandom_range(0, 2) == 0)
			return CHAR_DOT;
		do
			c = 8'($urandom_range(0, 255));
		while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_SPACE ||
			(c >= CHAR_TAB && c <= CHAR_CR));
		return c;
	endfunction

	// Drive one character and hold it until the transaction completes
	task send_char(input logic [7:0] c, input bit is_last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= c;
		last      <= is_last;
		do
			@(posedge clk);
		while (!in_ready);
		board.take_char(c, is_last);
		chars_sent++;
	endtask

	task send_text();
		for (int i = 0; i < text_buf.size(); i++)
			send_char(text_buf[i], i == text_buf.size() - 1);
		strings_sent++;
	endtask

	task send_str(input string s);
		text_buf.delete();
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
		send_text();
	endtask

	// Hold the sender off until every pending value has come out
	task drain_values();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending_values.size() != 0)
			@(posedge clk);
	endtask

	// Fill text_buf with one random string
	task build_random_text();
		int         r;
		int         n;
		longint     num;
		string      digits;
		text_buf.delete();
		if ($urandom_range(0, 99) < 70) begin
			// leading blanks and optional sign
			n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
			repeat (n) text_buf.push_back(pick_blank());
			r = $urandom_range(0, 2);
			if (r == 1)
				text_buf.push_back(CHAR_PLUS);
			else if (r == 2)
				text_buf.push_back(CHAR_MINUS);
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, 3)) text_buf.push_back(CHAR_ZERO);
			// digit run: short, near the int32 bound, or far past it
			r = $urandom_range(0, 9);
			if (r < 6) begin
				repeat ($urandom_range(1, 6)) text_buf.push_back(pick_digit());
			end else if (r < 8) begin
				case ($urandom_range(0, 5))
					0: num = 64'd2147483647;
					1: num = 64'd2147483648;
					2: num = 64'd2147483649;
					3: num = 64'd2147483646;
					4: num = 64'd4294967295;
					default: num = 64'd1000000000;
				endcase
				digits = $sformatf("%0d", num);
				for (int i = 0; i < digits.len(); i++)
					text_buf.push_back(digits[i]);
			end else begin
				repeat ($urandom_range(11, 22)) text_buf.push_back(pick_digit());
			end
			// tail after the digits
			case ($urandom_range(0, 3))
				1: begin
					text_buf.push_back(pick_stopper());
					repeat ($urandom_range(0, 4)) text_buf.push_back(8'($urandom_range(0, 255)));
				end
				2: begin
					text_buf.push_back(pick_blank());
					repeat ($urandom_range(0, 3)) text_buf.push_back(8'($urandom_range(0, 255)));
				end
				3: text_buf.push_back(pick_stopper());
				default: begin
				end
			endcase
		end else begin
			// noise: raw bytes mixed with digits, blanks and signs
			repeat ($urandom_range(1, 6)) begin
				r = $urandom_range(0, 99);
				if (r < 40)
					text_buf.push_back(8'($urandom_range(0, 255)));
				else if (r < 70)
					text_buf.push_back(pick_digit());
				else if (r < 85)
					text_buf.push_back(pick_blank());
				else
					text_buf.push_back(($urandom_range(0, 1) == 0) ? CHAR_PLUS : CHAR_MINUS);
			end
		end
	endtask

	// Stimulus and end of run
	initial begin
		int random_start;
		board     = new();
		arst_n    = 1'b0;
		in_valid  <= 1'b0;
		char_code <= 8'd0;
		last      <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed strings
		text_buf.delete();
		text_buf.push_back(8'd0);
		send_text();
		send_str("0");
		send_str("9");
		send_str("+12");
		send_str(" \t");
		send_str("-");
		send_str("+x");
		send_str(".5");
		send_str("7 ");
		send_str("-3.9z");
		text_buf.delete();
		text_buf.push_back(8'd255);
		send_text();
		drain_values();

		// random strings
		random_start = chars_sent;
		while (chars_sent - random_start < RANDOM_CHARS) begin
			if (strings_sent % 60 == 0)
				calm = ($urandom_range(0, 3) == 0);
			build_random_text();
			send_text();
			if ($urandom_range(0, 39) == 0)
				drain_values();
		end
		calm = 1'b0;
		drain_values();
		repeat (8) @(posedge clk);

		$display("Sent %0d strings (%0d characters), checked %0d values.",
			strings_sent, chars_sent, board.checked);
		$display("Covered blanks, signs, stray leads, terminators and int32 saturation.");
		if (board.errors == 0)
			$display("[decimal_text_to_int32] OK");
		else
			$display("[decimal_text_to_int32] ERROR");
		$finish;
	end

	// Output side: check each transaction, stall at random
	initial begin
		int hold;
		hold = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				board.compare_value(value);
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				hold = pick_gap();
				out_ready <= (hold == 0);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("[decimal_text_to_int32] ERROR");
		$finish;
	end

endmodule
